FILE: hdl/pst_pkg.sv
// Package for the Poisson spike thinning block: widths, constants, state and register codes.
// No dependencies.
`default_nettype none
package pst_pkg;

    localparam int TIME_W     = 32;
    localparam int RATE_W     = 24;
    localparam int RMAX_W     = 26;
    localparam int UNI_W      = 16;
    localparam int LN_W       = 20;
    localparam int DIVD_W     = 40;
    localparam int DIV_CNT_W  = 6;

    localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 6'd40;
    localparam logic [31:0] LN2_Q32     = 32'd2977044472;
    localparam logic [16:0] COS_A       = 17'd102944;
    localparam logic [15:0] COS_B       = 16'd42047;
    localparam logic [15:0] COS_C       = 16'd4640;
    localparam logic [15:0] ONE_Q15     = 16'd32768;
    localparam logic [15:0] QUARTER     = 16'd16384;
    localparam logic [16:0] RECIP_100   = 17'd83887;
    localparam logic [7:0]  PULSE_CYCLE = 8'd100;

    typedef enum logic [2:0] {
        ADDR_BASE_RATE    = 3'd0,
        ADDR_MOD_DEPTH    = 3'd1,
        ADDR_PHASE_STEP   = 3'd2,
        ADDR_PHASE_OFFSET = 3'd3,
        ADDR_PULSE_RATE   = 3'd4,
        ADDR_PULSE_START  = 3'd5,
        ADDR_PULSE_LENGTH = 3'd6,
        ADDR_END_TIME     = 3'd7
    } pst_addr_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_RMAX, ST_LOG0, ST_SQ, ST_SQN, ST_LN, ST_DIVS, ST_DIV,
        ST_TIME, ST_PH, ST_COS0, ST_X2, ST_T1, ST_T2, ST_T3, ST_C, ST_F,
        ST_CYC, ST_CYC2, ST_ACC, ST_CMP
    } pst_state_t;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [RMAX_W-1:0] divisor;
    } pst_div_req_t;

endpackage
`default_nettype wire

FILE: hdl/pst_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on pst_pkg.
`default_nettype none
module pst_div
    import pst_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire pst_div_req_t      req,
    output logic                   done,
    output logic [DIVD_W-1:0]      quotient
);

    logic [RMAX_W-1:0]    rem_reg, rem_next;
    logic [DIVD_W-1:0]    quo_reg, quo_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [RMAX_W:0]      trial;
    logic                 fits;

    assign trial = {rem_reg, quo_reg[DIVD_W-1]};
    assign fits  = trial >= {1'b0, req.divisor};

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next  = '0;
            quo_next  = req.dividend;
            cnt_next  = DIV_STEPS;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? RMAX_W'(trial - {1'b0, req.divisor}) : trial[RMAX_W-1:0];
            quo_next = {quo_reg[DIVD_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

FILE: hdl/poisson_spike_thinning.sv
// Poisson spike thinning top level: APB registers, trial sequencer, shared multiplier.
// Depends on pst_pkg and pst_div.
//
// A trial beat uses the shared 32x32 multiplier over sixteen squarings for the logarithm,
// then the 40-step divider makes the interval, and thirteen further steps give the cosine
// rate, pulse window and acceptance test. With a zero bound the divider is skipped. Restart
// beats and beats after the train has finished return their result in the cycle after
// acceptance. Input is taken only while the sequencer is idle and the result register is
// free or being read.
`default_nettype none
module poisson_spike_thinning
    import pst_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_cmd,
    input  wire logic [15:0] s_uniform_a,
    input  wire logic [15:0] s_uniform_b,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_spike,
    output logic [31:0]      m_spike_time,
    output logic             m_done_res
);

    logic [23:0] base_rate_reg, pulse_rate_reg;
    logic [15:0] mod_depth_reg, phase_offset_reg;
    logic [31:0] phase_step_reg, end_time_reg;
    logic [6:0]  pulse_start_reg, pulse_length_reg;
    logic        wr_en;
    pst_addr_t   addr;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign addr   = pst_addr_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_rate_reg    <= 24'd1048576;
            mod_depth_reg    <= '0;
            phase_step_reg   <= 32'd42949673;
            phase_offset_reg <= '0;
            pulse_rate_reg   <= '0;
            pulse_start_reg  <= '0;
            pulse_length_reg <= '0;
            end_time_reg     <= 32'd65536000;
        end else if (wr_en) begin
            unique case (addr)
                ADDR_BASE_RATE:    base_rate_reg    <= pwdata[23:0];
                ADDR_MOD_DEPTH:    mod_depth_reg    <= pwdata[15:0];
                ADDR_PHASE_STEP:   phase_step_reg   <= pwdata;
                ADDR_PHASE_OFFSET: phase_offset_reg <= pwdata[15:0];
                ADDR_PULSE_RATE:   pulse_rate_reg   <= pwdata[23:0];
                ADDR_PULSE_START:  pulse_start_reg  <= pwdata[6:0];
                ADDR_PULSE_LENGTH: pulse_length_reg <= pwdata[6:0];
                ADDR_END_TIME:     end_time_reg     <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (addr)
            ADDR_BASE_RATE:    prdata = {8'd0, base_rate_reg};
            ADDR_MOD_DEPTH:    prdata = {16'd0, mod_depth_reg};
            ADDR_PHASE_STEP:   prdata = phase_step_reg;
            ADDR_PHASE_OFFSET: prdata = {16'd0, phase_offset_reg};
            ADDR_PULSE_RATE:   prdata = {8'd0, pulse_rate_reg};
            ADDR_PULSE_START:  prdata = {25'd0, pulse_start_reg};
            ADDR_PULSE_LENGTH: prdata = {25'd0, pulse_length_reg};
            ADDR_END_TIME:     prdata = end_time_reg;
            default:           prdata = '0;
        endcase
    end

    pst_state_t        state_reg, state_next;
    logic [31:0]       mul_a, mul_b;
    logic [63:0]       prod_reg;
    logic [15:0]       ua_reg, ua_next, ub_reg, ub_next;
    logic [RMAX_W-1:0] rmax_reg, rmax_next;
    logic [3:0]        p_reg, p_next, sq_cnt_reg, sq_cnt_next;
    logic [31:0]       m_reg, m_next;
    logic [15:0]       f_reg, f_next;
    logic [DIVD_W-1:0] ival_reg, ival_next;
    logic [31:0]       cur_reg, cur_next;
    logic              fin_reg, fin_next;
    logic [14:0]       z_reg, z_next, x2_reg, x2_next;
    logic              neg_reg, neg_next;
    logic [26:0]       rate_reg, rate_next;
    logic              ov_reg, ov_next;
    logic              spike_reg, spike_next, done_reg, done_next;
    logic [31:0]       stime_reg, stime_next;
    logic              s_fire, slot_free;
    pst_div_req_t      div_req;
    logic              div_done;
    logic [DIVD_W-1:0] div_q;

    logic [15:0] k;
    logic [3:0]  lead;
    logic [31:0] msq;
    logic [20:0] nl2;
    logic [40:0] tsum;
    logic [15:0] ph, s;
    logic [16:0] zw;
    logic [16:0] t3, r;
    logic [15:0] cval, dc, cyc16;
    logic [16:0] factor;
    logic [7:0]  win_end;
    logic        in_win, accept;

    assign slot_free = !ov_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE) && slot_free;
    assign s_fire    = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_fire && !s_cmd && !fin_reg) state_next = ST_RMAX;
            ST_RMAX: state_next = ST_LOG0;
            ST_LOG0: state_next = ST_SQ;
            ST_SQ:   state_next = ST_SQN;
            ST_SQN:  state_next = (sq_cnt_reg == 4'd15) ? ST_LN : ST_SQ;
            ST_LN:   state_next = ST_DIVS;
            ST_DIVS: state_next = (rmax_reg == '0) ? ST_TIME : ST_DIV;
            ST_DIV:  if (div_done) state_next = ST_TIME;
            ST_TIME: state_next = ST_PH;
            ST_PH:   state_next = ST_COS0;
            ST_COS0: state_next = ST_X2;
            ST_X2:   state_next = ST_T1;
            ST_T1:   state_next = ST_T2;
            ST_T2:   state_next = ST_T3;
            ST_T3:   state_next = ST_C;
            ST_C:    state_next = ST_F;
            ST_F:    state_next = ST_CYC;
            ST_CYC:  state_next = ST_CYC2;
            ST_CYC2: state_next = ST_ACC;
            ST_ACC:  state_next = ST_CMP;
            ST_CMP:  if (slot_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        k = (ua_reg == '0) ? 16'd1 : ua_reg;
        lead = '0;
        for (int i = 1; i < 16; i++) begin
            if (k[i]) lead = 4'(i);
        end
        msq     = prod_reg[61:30];
        nl2     = {5'd16 - {1'b0, p_reg}, 16'd0} - {5'd0, f_reg};
        tsum    = {9'd0, cur_reg} + {1'b0, ival_reg};
        ph      = prod_reg[47:32] + phase_offset_reg;
        s       = ph + QUARTER;
        case (s[15:14])
            2'd0:    zw = {1'b0, s};
            2'd1:    zw = 17'd32768 - {1'b0, s};
            2'd2:    zw = {1'b0, s} - 17'd32768;
            default: zw = 17'd65536 - {1'b0, s};
        endcase
        t3      = COS_A - {1'b0, prod_reg[29:14]};
        r       = prod_reg[31:15];
        cval    = (r > 17'd32768) ? ONE_Q15 : r[15:0];
        dc      = prod_reg[30:15];
        if (!neg_reg) factor = {1'b0, ONE_Q15} + {1'b0, dc};
        else          factor = (dc > ONE_Q15) ? 17'd0 : {1'b0, ONE_Q15 - dc};
        cyc16   = cur_reg[31:16] - prod_reg[15:0];
        win_end = {1'b0, pulse_start_reg} + {1'b0, pulse_length_reg};
        in_win  = (cyc16[6:0] >= pulse_start_reg) && ({1'b0, cyc16[6:0]} < win_end);
        accept  = {1'b0, prod_reg[41:0]} <= {rate_reg, 16'd0};
    end

    always_comb begin
        mul_a       = '0;
        mul_b       = '0;
        ua_next     = ua_reg;
        ub_next     = ub_reg;
        rmax_next   = rmax_reg;
        p_next      = p_reg;
        sq_cnt_next = sq_cnt_reg;
        m_next      = m_reg;
        f_next      = f_reg;
        ival_next   = ival_reg;
        cur_next    = cur_reg;
        fin_next    = fin_reg;
        z_next      = z_reg;
        x2_next     = x2_reg;
        neg_next    = neg_reg;
        rate_next   = rate_reg;
        ov_next     = ov_reg && !m_ready;
        spike_next  = spike_reg;
        done_next   = done_reg;
        stime_next  = stime_reg;
        div_req     = '{start: 1'b0, dividend: {prod_reg[51:32], 20'd0}, divisor: rmax_reg};
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    ua_next = s_uniform_a;
                    ub_next = s_uniform_b;
                    if (s_cmd) begin
                        cur_next   = '0;
                        fin_next   = 1'b0;
                        ov_next    = 1'b1;
                        spike_next = 1'b0;
                        stime_next = '0;
                        done_next  = 1'b0;
                    end else if (fin_reg) begin
                        ov_next    = 1'b1;
                        spike_next = 1'b0;
                        stime_next = cur_reg;
                        done_next  = 1'b1;
                    end
                end
            end
            ST_RMAX: begin
                mul_a = {8'd0, base_rate_reg};
                mul_b = {15'd0, {1'b0, ONE_Q15} + {1'b0, mod_depth_reg}};
            end
            ST_LOG0: begin
                rmax_next   = RMAX_W'(prod_reg[40:15]) + RMAX_W'(pulse_rate_reg);
                p_next      = lead;
                m_next      = 32'({16'd0, k} << (5'd30 - {1'b0, lead}));
                f_next      = '0;
                sq_cnt_next = '0;
            end
            ST_SQ: begin
                mul_a = m_reg;
                mul_b = m_reg;
            end
            ST_SQN: begin
                m_next      = msq[31] ? {1'b0, msq[31:1]} : msq;
                f_next      = {f_reg[14:0], msq[31]};
                sq_cnt_next = sq_cnt_reg + 1'b1;
            end
            ST_LN: begin
                mul_a = {11'd0, nl2};
                mul_b = LN2_Q32;
            end
            ST_DIVS: begin
                if (rmax_reg == '0) ival_next = '1;
                else                div_req.start = 1'b1;
            end
            ST_DIV: if (div_done) ival_next = div_q;
            ST_TIME: cur_next = (|tsum[40:32]) ? '1 : tsum[31:0];
            ST_PH: begin
                mul_a = cur_reg;
                mul_b = phase_step_reg;
            end
            ST_COS0: begin
                z_next   = zw[14:0];
                neg_next = s[15];
            end
            ST_X2: begin
                mul_a = {17'd0, z_reg};
                mul_b = {17'd0, z_reg};
            end
            ST_T1: begin
                x2_next = prod_reg[28:14];
                mul_a   = {16'd0, COS_C};
                mul_b   = {17'd0, prod_reg[28:14]};
            end
            ST_T2: begin
                mul_a = {16'd0, COS_B - {3'd0, prod_reg[26:14]}};
                mul_b = {17'd0, x2_reg};
            end
            ST_T3: begin
                mul_a = {15'd0, t3};
                mul_b = {17'd0, z_reg};
            end
            ST_C: begin
                mul_a = {16'd0, mod_depth_reg};
                mul_b = {16'd0, cval};
            end
            ST_F: begin
                mul_a = {8'd0, base_rate_reg};
                mul_b = {15'd0, factor};
            end
            ST_CYC: begin
                rate_next = {1'b0, prod_reg[40:15]};
                mul_a     = {16'd0, cur_reg[31:16]};
                mul_b     = {15'd0, RECIP_100};
            end
            ST_CYC2: begin
                mul_a = {22'd0, prod_reg[32:23]};
                mul_b = {24'd0, PULSE_CYCLE};
            end
            ST_ACC: begin
                if (in_win) rate_next = rate_reg + {3'd0, pulse_rate_reg};
                mul_a = {16'd0, ub_reg};
                mul_b = {6'd0, rmax_reg};
            end
            ST_CMP: begin
                mul_a = {16'd0, ub_reg};
                mul_b = {6'd0, rmax_reg};
                if (slot_free) begin
                    ov_next    = 1'b1;
                    stime_next = cur_reg;
                    spike_next = accept && (cur_reg < end_time_reg);
                    done_next  = accept && (cur_reg >= end_time_reg);
                    if (accept && (cur_reg >= end_time_reg)) fin_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    pst_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cur_reg   <= '0;
            fin_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            cur_reg   <= cur_next;
            fin_reg   <= fin_next;
            ov_reg    <= ov_next;
        end
        prod_reg   <= mul_a * mul_b;
        ua_reg     <= ua_next;
        ub_reg     <= ub_next;
        rmax_reg   <= rmax_next;
        p_reg      <= p_next;
        sq_cnt_reg <= sq_cnt_next;
        m_reg      <= m_next;
        f_reg      <= f_next;
        ival_reg   <= ival_next;
        z_reg      <= z_next;
        x2_reg     <= x2_next;
        neg_reg    <= neg_next;
        rate_reg   <= rate_next;
        spike_reg  <= spike_next;
        done_reg   <= done_next;
        stime_reg  <= stime_next;
    end

    assign m_valid      = ov_reg;
    assign m_spike      = spike_reg;
    assign m_spike_time = stime_reg;
    assign m_done_res   = done_reg;

endmodule
`default_nettype wire

FILE: hdl/pst_checker.sv
// Port-level checker for poisson_spike_thinning, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none
module pst_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        s_cmd,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic        m_spike,
    input wire logic [31:0] m_spike_time,
    input wire logic        m_done_res
);

    a_restart_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_cmd |=>
            m_valid && !m_spike && !m_done_res && m_spike_time == 32'd0)
        else $error("restart beat gave wrong result");

    a_spike_not_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_spike |-> !m_done_res)
        else $error("spike and done together");

    a_no_take_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while result blocked");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_spike_time))
        else $error("result beat dropped or changed");

endmodule

bind poisson_spike_thinning pst_checker u_pst_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_cmd        (s_cmd),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_spike      (m_spike),
    .m_spike_time (m_spike_time),
    .m_done_res   (m_done_res)
);
`default_nettype wire
